// ===== hw/rtl/srip_pkg.sv =====
// ----------------------------------------------------------------------------
// srip_pkg: shared types and codes of the radix integer parser
// Character and result request formats, character classes, phases, status.
// ----------------------------------------------------------------------------
package srip_pkg;

	// widths of the result fields
	localparam int VALUE_BITS  = 32;
	localparam int COUNT_BITS  = 10;
	localparam int STATUS_BITS = 3;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// classified character
	localparam int DIGIT_BITS = 6;
	localparam int KIND_BITS  = 3;

	localparam logic [KIND_BITS-1:0] KIND_DIGIT  = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_MINUS  = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_HASH   = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_DOLLAR = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_PLUS   = 3'd4;
	localparam logic [KIND_BITS-1:0] KIND_UNDER  = 3'd5;
	localparam logic [KIND_BITS-1:0] KIND_OTHER  = 3'd6;

	// ASCII codes
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] LETTER_OFS = 8'd10;

	// parse phases
	localparam logic [1:0] PH_SIGN   = 2'd0;
	localparam logic [1:0] PH_SIGIL  = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// radix selects
	localparam logic [1:0] RAD_36 = 2'd0;
	localparam logic [1:0] RAD_10 = 2'd1;
	localparam logic [1:0] RAD_16 = 2'd2;
	localparam logic [1:0] RAD_2  = 2'd3;

	localparam logic [DIGIT_BITS-1:0] BASE_36 = 6'd36;
	localparam logic [DIGIT_BITS-1:0] BASE_10 = 6'd10;
	localparam logic [DIGIT_BITS-1:0] BASE_16 = 6'd16;
	localparam logic [DIGIT_BITS-1:0] BASE_2  = 6'd2;

	// result status
	localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_BAD_START  = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_NEG_BINARY = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_BAD_DIGIT  = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_NO_DIGITS  = 3'd4;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} chr_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0]        consumed;
		logic [STATUS_BITS-1:0]       status;
		logic                         overflow;
	} res_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [DIGIT_BITS-1:0] dval;
		logic                  last;
	} cls_t;

endpackage

// ===== hw/rtl/srip_front.sv =====
// ----------------------------------------------------------------------------
// srip_front: character classifier
// Accepts character requests and pushes their class and digit value to the queue.
// ----------------------------------------------------------------------------
module srip_front import srip_pkg::*; (
	input  logic chr_valid,
	output logic chr_stall,
	input  chr_t chr_data,
	input  logic q_full,
	output logic q_push,
	output cls_t q_item
);

	// stall while the queue has no room
	assign chr_stall = q_full;
	assign q_push    = chr_valid & ~q_full;

	// classify the character
	always_comb begin
		q_item.last = chr_data.last;
		q_item.dval = '0;
		q_item.kind = KIND_OTHER;
		if (chr_data.ch >= CH_0 && chr_data.ch <= CH_9) begin
			q_item.kind = KIND_DIGIT;
			q_item.dval = DIGIT_BITS'(chr_data.ch - CH_0);
		end else if (chr_data.ch >= CH_LA && chr_data.ch <= CH_LZ) begin
			q_item.kind = KIND_DIGIT;
			q_item.dval = DIGIT_BITS'(chr_data.ch - CH_LA + LETTER_OFS);
		end else if (chr_data.ch >= CH_UA && chr_data.ch <= CH_UZ) begin
			q_item.kind = KIND_DIGIT;
			q_item.dval = DIGIT_BITS'(chr_data.ch - CH_UA + LETTER_OFS);
		end else begin
			case (chr_data.ch)
				CH_MINUS:  q_item.kind = KIND_MINUS;
				CH_HASH:   q_item.kind = KIND_HASH;
				CH_DOLLAR: q_item.kind = KIND_DOLLAR;
				CH_PLUS:   q_item.kind = KIND_PLUS;
				CH_UNDER:  q_item.kind = KIND_UNDER;
				default:   q_item.kind = KIND_OTHER;
			endcase
		end
	end

endmodule

// ===== hw/rtl/srip_queue.sv =====
// ----------------------------------------------------------------------------
// srip_queue: classified character queue
// Small FIFO that decouples the classifier from the parse engine.
// ----------------------------------------------------------------------------
module srip_queue import srip_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_item,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output cls_t head
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

	cls_t                entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];

	// store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/srip_back.sv =====
// ----------------------------------------------------------------------------
// srip_back: parse engine
// Runs the literal state machine one character per cycle while the result slot is free, and holds the result.
// ----------------------------------------------------------------------------
module srip_back import srip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_nonempty,
	input  cls_t q_head,
	output logic q_pop,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	localparam int PROD_BITS = VALUE_BITS + DIGIT_BITS + 1;
	localparam logic [PROD_BITS-1:0] MAG_LIMIT = PROD_BITS'({(VALUE_BITS-1){1'b1}});
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [1:0]            phase_q;
	logic                  neg_q;
	logic [1:0]            rad_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  dseen_q;
	logic                  ovf_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic [1:0]            n_phase;
	logic                  n_neg;
	logic [1:0]            n_rad;
	logic [VALUE_BITS-1:0] n_acc;
	logic [COUNT_BITS-1:0] n_cnt;
	logic                  n_dseen;
	logic                  n_ovf;
	logic                  emit;
	logic                  frame_clear;
	logic [STATUS_BITS-1:0] emit_st;
	logic                  digit_path;
	logic                  tail;
	logic [DIGIT_BITS-1:0] base;
	logic [PROD_BITS-1:0]  prod;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  go;
	res_t                  emit_res;

	// advance when the result slot is free next cycle
	assign go        = q_nonempty & (~res_valid_q | ~res_stall);
	assign q_pop     = go;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

	// digit step: multiply by the base and add
	always_comb begin
		case (n_rad)
			RAD_36:  base = BASE_36;
			RAD_10:  base = BASE_10;
			RAD_16:  base = BASE_16;
			RAD_2:   base = BASE_2;
			default: base = BASE_36;
		endcase
		prod = PROD_BITS'(acc_q) * PROD_BITS'(base) + PROD_BITS'(q_head.dval);
	end

	// next state for the character at the queue head
	always_comb begin
		n_phase     = phase_q;
		n_neg       = neg_q;
		n_rad       = rad_q;
		n_acc       = acc_q;
		n_cnt       = cnt_q;
		n_dseen     = dseen_q;
		n_ovf       = ovf_q;
		emit        = 1'b0;
		frame_clear = 1'b0;
		emit_st     = ST_OK;
		digit_path  = 1'b0;
		tail        = 1'b0;
		if (phase_q == PH_DONE) begin
			frame_clear = q_head.last;
		end else if (phase_q == PH_SIGN && q_head.kind == KIND_MINUS) begin
			n_neg   = 1'b1;
			n_cnt   = cnt_inc;
			n_phase = PH_SIGIL;
			if (q_head.last) begin
				emit    = 1'b1;
				emit_st = ST_BAD_START;
			end
		end else if (phase_q != PH_DIGITS) begin
			if (q_head.kind == KIND_HASH || q_head.kind == KIND_DOLLAR ||
					q_head.kind == KIND_PLUS) begin
				if (q_head.kind == KIND_PLUS && neg_q) begin
					emit    = 1'b1;
					emit_st = ST_NEG_BINARY;
				end else begin
					n_rad   = (q_head.kind == KIND_HASH) ? RAD_10 :
						(q_head.kind == KIND_DOLLAR) ? RAD_16 : RAD_2;
					n_cnt   = cnt_inc;
					n_phase = PH_DIGITS;
					if (q_head.last) begin
						emit    = 1'b1;
						emit_st = dseen_q ? ST_OK : ST_NO_DIGITS;
					end
				end
			end else if (q_head.kind != KIND_DIGIT) begin
				emit    = 1'b1;
				emit_st = ST_BAD_START;
			end else begin
				n_rad      = RAD_36;
				n_phase    = PH_DIGITS;
				digit_path = 1'b1;
			end
		end else begin
			digit_path = 1'b1;
		end

		// digits, underscores and terminators
		if (digit_path) begin
			if (q_head.kind == KIND_DIGIT) begin
				if (q_head.dval >= base) begin
					emit    = 1'b1;
					emit_st = ST_BAD_DIGIT;
				end else begin
					n_ovf   = ovf_q | (prod > MAG_LIMIT);
					n_acc   = prod[VALUE_BITS-1:0];
					n_dseen = 1'b1;
					n_cnt   = cnt_inc;
					tail    = 1'b1;
				end
			end else if (q_head.kind == KIND_UNDER) begin
				n_cnt = cnt_inc;
				tail  = 1'b1;
			end else begin
				emit    = 1'b1;
				emit_st = dseen_q ? ST_OK : ST_NO_DIGITS;
			end
			if (tail && q_head.last) begin
				emit    = 1'b1;
				emit_st = n_dseen ? ST_OK : ST_NO_DIGITS;
			end
		end
	end

	// build the result; errors give zeros
	always_comb begin
		emit_res.status   = emit_st;
		emit_res.value    = '0;
		emit_res.consumed = '0;
		emit_res.overflow = 1'b0;
		if (emit_st == ST_OK) begin
			emit_res.value    = n_neg ? -n_acc : n_acc;
			emit_res.consumed = n_cnt;
			emit_res.overflow = n_ovf;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (go && emit) begin
			res_q <= emit_res;
		end
	end

	// update parse state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIGN;
			neg_q       <= 1'b0;
			rad_q       <= RAD_36;
			acc_q       <= '0;
			cnt_q       <= '0;
			dseen_q     <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (go && emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (go) begin
				if (emit || frame_clear) begin
					phase_q <= (q_head.last) ? PH_SIGN : PH_DONE;
					neg_q   <= 1'b0;
					rad_q   <= RAD_36;
					acc_q   <= '0;
					cnt_q   <= '0;
					dseen_q <= 1'b0;
					ovf_q   <= 1'b0;
				end else begin
					phase_q <= n_phase;
					neg_q   <= n_neg;
					rad_q   <= n_rad;
					acc_q   <= n_acc;
					cnt_q   <= n_cnt;
					dseen_q <= n_dseen;
					ovf_q   <= n_ovf;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/sigil_radix_integer_parser.sv =====
// A character request is written into the queue when accepted and is parsed once it
// reaches the queue head and the result slot is free; its result request, if any, is registered.
// The parse engine takes one character per cycle while the result slot is free;
// its digit step (multiply by the base and add) is combinational.
// Reset: arst_n clears the queue, the parse state and the result valid at once.
// ----------------------------------------------------------------------------
// sigil_radix_integer_parser: radix-prefixed integer literal parser
// Classifier, queue and parse engine; one result request per character frame.
// ----------------------------------------------------------------------------
module sigil_radix_integer_parser import srip_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic chr_valid,
	output logic chr_stall,
	input  chr_t chr_data,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_nonempty;
	cls_t q_item;
	cls_t q_head;

	// classify incoming characters
	srip_front u_front (
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr_data  (chr_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item)
	);

	// decouple front and back
	srip_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	// parse and deliver results
	srip_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

endmodule

// ===== dv/tb_sigil_radix_integer_parser.sv =====
// ----------------------------------------------------------------------------
// tb_sigil_radix_integer_parser: self-checking bench of the radix integer parser
// Feeds framed character requests, predicts each result request with an
// independent parser model, and compares every field. Covers all sigils,
// error paths, wrap and overflow, count saturation and both-side backpressure.
// ----------------------------------------------------------------------------
module tb_sigil_radix_integer_parser;
	import srip_pkg::*;

	typedef logic [7:0] char_q_t[$];

	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;
	localparam int NOT_DIGIT = 64;
	localparam int HOLD_CYCLES = 150;
	localparam longint unsigned MAG_LIMIT = 64'h7FFF_FFFF;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic clk;
	logic arst_n;
	logic chr_valid;
	logic chr_stall;
	chr_t chr_data;
	logic res_valid;
	logic res_stall;
	res_t res_data;

	// predicted parser state
	logic [1:0]            lit_phase;
	logic                  lit_neg;
	logic [1:0]            lit_radix;
	logic [VALUE_BITS-1:0] lit_acc;
	logic [COUNT_BITS-1:0] lit_count;
	logic                  lit_digit_seen;
	logic                  lit_ovf_seen;

	res_t pending_results[$];

	bit idle_on;
	int hold_results;
	int cycle_count;
	int chars_sent;
	int frames_sent;
	int results_checked;
	int mismatches;
	int overflow_hits;
	int status_hits[5];

	sigil_radix_integer_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr_data  (chr_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// parser prediction
	// ------------------------------------------------------------------
	function automatic void clear_literal();
		lit_phase = PH_SIGN;
		lit_neg = 1'b0;
		lit_radix = RAD_36;
		lit_acc = '0;
		lit_count = '0;
		lit_digit_seen = 1'b0;
		lit_ovf_seen = 1'b0;
	endfunction

	function automatic void count_char();
		if (lit_count != COUNT_MAX) lit_count = lit_count + 1'b1;
	endfunction

	function automatic int digit_value(logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
		return NOT_DIGIT;
	endfunction

	function automatic int radix_base(logic [1:0] sel);
		case (sel)
			RAD_10: return int'(BASE_10);
			RAD_16: return int'(BASE_16);
			RAD_2: return int'(BASE_2);
			default: return int'(BASE_36);
		endcase
	endfunction

	// queue one predicted result; end of frame restores the idle state
	function automatic void push_result(logic [STATUS_BITS-1:0] st, logic l);
		res_t r;
		r = '0;
		r.status = st;
		if (st == ST_OK) begin
			r.value = lit_neg ? (~lit_acc + 1'b1) : lit_acc;
			r.consumed = lit_count;
			r.overflow = lit_ovf_seen;
		end
		pending_results.push_back(r);
		if (l) clear_literal();
		else lit_phase = PH_DONE;
	endfunction

	function automatic void close_literal(logic l);
		push_result(lit_digit_seen ? ST_OK : ST_NO_DIGITS, l);
	endfunction

	function automatic void parse_char(logic [7:0] c, logic l);
		int d;
		int base;
		logic [63:0] acc_wide;
		d = digit_value(c);
		// skip the rest of a frame that already gave its result
		if (lit_phase == PH_DONE) begin
			if (l) clear_literal();
			return;
		end
		if (lit_phase == PH_SIGN && c == CH_MINUS) begin
			lit_neg = 1'b1;
			count_char();
			lit_phase = PH_SIGIL;
			if (l) push_result(ST_BAD_START, 1'b1);
			return;
		end
		if (lit_phase == PH_SIGN || lit_phase == PH_SIGIL) begin
			if (c == CH_HASH || c == CH_DOLLAR || c == CH_PLUS) begin
				if (c == CH_PLUS && lit_neg) begin
					push_result(ST_NEG_BINARY, l);
					return;
				end
				lit_radix = (c == CH_HASH) ? RAD_10 : (c == CH_DOLLAR) ? RAD_16 : RAD_2;
				count_char();
				lit_phase = PH_DIGITS;
				if (l) close_literal(1'b1);
				return;
			end
			if (d == NOT_DIGIT) begin
				push_result(ST_BAD_START, l);
				return;
			end
			// bare alphanumeric start selects base 36 and is the first digit
			lit_radix = RAD_36;
			lit_phase = PH_DIGITS;
		end
		if (d != NOT_DIGIT) begin
			base = radix_base(lit_radix);
			if (d >= base) begin
				push_result(ST_BAD_DIGIT, l);
				return;
			end
			if (64'(lit_acc) > (MAG_LIMIT - 64'(d)) / 64'(base)) lit_ovf_seen = 1'b1;
			acc_wide = 64'(lit_acc) * 64'(base) + 64'(d);
			lit_acc = acc_wide[VALUE_BITS-1:0];
			lit_digit_seen = 1'b1;
			count_char();
		end else if (c == CH_UNDER) begin
			count_char();
		end else begin
			close_literal(l);
			return;
		end
		if (l) close_literal(1'b1);
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic void check_result(res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			if (mismatches < REPORT_LIMIT)
				$display("unexpected result: value %0d consumed %0d status %0d overflow %0b",
					got.value, got.consumed, got.status, got.overflow);
			mismatches++;
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		status_hits[want.status]++;
		if (want.overflow) overflow_hits++;
		if (got.value !== want.value || got.consumed !== want.consumed ||
				got.status !== want.status || got.overflow !== want.overflow) begin
			if (mismatches < REPORT_LIMIT)
				$display("result %0d mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
					results_checked, want.value, want.consumed, want.status, want.overflow,
					got.value, got.consumed, got.status, got.overflow);
			mismatches++;
		end
	endfunction

	// check results and drive stall: a long hold when requested, else random bursts while idle_on is set
	initial begin : result_side
		int burst;
		burst = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid === 1'b1 && res_stall === 1'b0) check_result(res_data);
			if (hold_results > 0) begin
				res_stall <= 1'b1;
				hold_results--;
			end else if (burst > 0) begin
				res_stall <= 1'b1;
				burst--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				res_stall <= 1'b1;
				burst = $urandom_range(1, 12) - 1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_results.size());
		$display("sigil_radix_integer_parser test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// character requests
	// ------------------------------------------------------------------
	task automatic send_char(logic [7:0] c, logic l);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			chr_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		chr_valid <= 1'b1;
		chr_data <= '{ch: c, last: l};
		do @(posedge clk); while (chr_stall);
		parse_char(c, l);
		chars_sent++;
	endtask

	task automatic send_frame(char_q_t f);
		for (int i = 0; i < f.size(); i++) send_char(f[i], i == f.size() - 1);
		frames_sent++;
	endtask

	task automatic send_text(string s);
		char_q_t q;
		q = {};
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		send_frame(q);
	endtask

	// hold the sender until every predicted result has come back
	task automatic wait_drained();
		chr_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic logic [7:0] digit_char(int d, bit upper);
		if (d < 10) return CH_0 + 8'(d);
		return (upper ? CH_UA : CH_LA) + 8'(d - 10);
	endfunction

	function automatic logic [7:0] other_char();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255));
		while (digit_value(c) != NOT_DIGIT || c == CH_UNDER);
		return c;
	endfunction

	// mostly well-formed literals with random content, the rest noise
	function automatic char_q_t random_frame();
		char_q_t f;
		int sig;
		int base;
		int n;
		int d;
		int term;
		f = {};
		if ($urandom_range(0, 9) < 8) begin
			if ($urandom_range(0, 3) == 0) f.push_back(CH_MINUS);
			sig = $urandom_range(0, 3);
			case (sig)
				1: begin f.push_back(CH_HASH); base = 10; end
				2: begin f.push_back(CH_DOLLAR); base = 16; end
				3: begin f.push_back(CH_PLUS); base = 2; end
				default: base = 36;
			endcase
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
			if (sig == 0 && n == 0) n = 1;
			for (int i = 0; i < n; i++) begin
				if (!(sig == 0 && i == 0) && $urandom_range(0, 6) == 0) f.push_back(CH_UNDER);
				d = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 35) : $urandom_range(0, base - 1);
				f.push_back(digit_char(d, $urandom_range(0, 1)));
			end
			// end the number by frame end, NUL or a stray character
			term = $urandom_range(0, 3);
			if (term == 1) f.push_back(8'h00);
			else if (term == 2) f.push_back(other_char());
			if (term != 0) repeat ($urandom_range(0, 3)) f.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 5)) begin
				case ($urandom_range(0, 9))
					0: f.push_back(CH_MINUS);
					1: f.push_back(CH_HASH);
					2: f.push_back(CH_DOLLAR);
					3: f.push_back(CH_PLUS);
					4: f.push_back(CH_UNDER);
					5: f.push_back(8'h00);
					default: f.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
		return f;
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		char_q_t q;
		send_text("-");
		send_text("--");
		q = {8'h00};
		send_frame(q);
		q = {8'hFF};
		send_frame(q);
		send_text("-+");
		send_text("#");
		send_text("$_");
		send_text("+2");
		send_text("z");
		send_text("-9");
		send_text("#1 x");
		send_text("$Af_");
	endtask

	task automatic test_value_extremes();
		char_q_t q;
		send_text("#2147483647");
		send_text("-#2147483648");
		send_text("$FFFFFFFF");
		send_text("-zik0zj");
		send_text("zik0zk");
		q = {CH_PLUS};
		repeat (32) q.push_back(CH_0 + 8'd1);
		send_frame(q);
	endtask

	// stall results for a long stretch so the block backs up its input
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_results = HOLD_CYCLES;
		for (int i = 0; i < 40; i++) begin
			if (i % 3 == 0) send_text("-#42");
			else send_text("7");
		end
		idle_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_count_saturation();
		char_q_t q;
		q = {CH_DOLLAR};
		for (int i = 0; i < 1100; i++) q.push_back((i % 200 == 0) ? CH_0 + 8'd3 : CH_UNDER);
		q.push_back(CH_0 + 8'd7);
		send_frame(q);
	endtask

	task automatic test_random_frames(int n);
		int start;
		start = chars_sent;
		while (chars_sent - start < n) send_frame(random_frame());
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		chr_valid <= 1'b0;
		chr_data <= '0;
		idle_on = 1'b1;
		hold_results = 0;
		chars_sent = 0;
		frames_sent = 0;
		results_checked = 0;
		mismatches = 0;
		overflow_hits = 0;
		foreach (status_hits[i]) status_hits[i] = 0;
		clear_literal();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_value_extremes();
		wait_drained();
		test_backpressure();
		test_count_saturation();
		test_random_frames(420);
		idle_on = 1'b0;
		test_random_frames(150);

		// drain, then allow the pipeline latency to settle
		chr_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d characters in %0d frames, %0d results checked, %0d with overflow",
			chars_sent, frames_sent, results_checked, overflow_hits);
		$display("status mix ok %0d, bad start %0d, negative binary %0d, bad digit %0d, no digits %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("sigil_radix_integer_parser test passed");
		end else begin
			$display("sigil_radix_integer_parser test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/srip_pkg.sv
hw/rtl/srip_front.sv
hw/rtl/srip_queue.sv
hw/rtl/srip_back.sv
hw/rtl/sigil_radix_integer_parser.sv
dv/tb_sigil_radix_integer_parser.sv
